### rtl/sdsh_pkg.sv
// package: shared types and constants of the sd card spi host sequencer
package sdsh_pkg;

  localparam int BLOCK_BYTES_DEF = 512;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_RETURN = 2'd1,
    OP_WDATA  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_SYNC  = 2'd3;

  localparam logic [1:0] CFG_IDLE_CLK = 2'd0;
  localparam logic [1:0] CFG_POLL     = 2'd1;
  localparam logic [1:0] CFG_RETRY    = 2'd2;
  localparam logic [1:0] CFG_BUSY     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_NOTINIT = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MMC  = 2'd1;
  localparam logic [1:0] KIND_SDB  = 2'd2;
  localparam logic [1:0] KIND_SDHC = 2'd3;

  typedef enum logic [16:0] {
    P_IDLE  = 17'h00001,
    P_CLK   = 17'h00002,
    P_CMD   = 17'h00004,
    P_POLL  = 17'h00008,
    P_OCR   = 17'h00010,
    P_PULSE = 17'h00020,
    P_RTOK  = 17'h00040,
    P_RDAT  = 17'h00080,
    P_RCRC  = 17'h00100,
    P_WTOK  = 17'h00200,
    P_WNEED = 17'h00400,
    P_WDAT  = 17'h00800,
    P_WCRC  = 17'h01000,
    P_WRESP = 17'h02000,
    P_WBUSY = 17'h04000,
    P_SYNC  = 17'h08000,
    P_FINAL = 17'h10000
  } phase_t;

  typedef enum logic [3:0] {
    X_CMD0, X_CMD8, X_OCR8, X_V2_55, X_V2_41, X_CMD58, X_OCR58, X_V1_55,
    X_V1_PROBE, X_V1L_55, X_V1_LOOP, X_CMD16, X_CMD17, X_CMD24
  } cont_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  request;
    logic [31:0] sector;
    logic [7:0]  block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select_low;
    logic       want_write_data;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
    logic [1:0] card_kind;
  } out_item_t;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_SEND_IF = 6'd8;
  localparam logic [5:0] CMD_OP_MMC  = 6'd1;
  localparam logic [5:0] CMD_BLKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ    = 6'd17;
  localparam logic [5:0] CMD_WRITE   = 6'd24;
  localparam logic [5:0] CMD_APP_OP  = 6'd41;
  localparam logic [5:0] CMD_APP     = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

endpackage

### rtl/sd_card_spi_host_sequencer_core.sv
// top level: sd card spi mode host sequencer, one byte exchange per transfer
//
// usage: in_ carries start requests, bytes returned by the card, and write
// data bytes. each accepted input transfer yields exactly one out_ transfer
// naming the next byte to shift (tx_byte/tx_valid), the chip-select level,
// whether a write data byte is wanted, any read block byte, and done/status.
// cfg_ writes the four limit registers (idle clocks, response polls, init
// retries, busy timeout); write only while the block is idle.
// result: the result of an input transfer appears in the cycle after it is
// accepted, from a single result register fed by the state machine.
// throughput: one input transfer per cycle while the result register drains;
// the only loop is the sequencer state update.
// stall: if out_ready is low the result register holds; in_ready stays high
// while the result register is empty or being drained this cycle, so
// a waiting result blocks further input until it is drained.
// reset: synchronous active low; limits return to 10/10/1000/5000, the
// card is marked uninitialized, chip select deasserted, output empty.
module sd_card_spi_host_sequencer_core #(
  parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdsh_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sdsh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int BIW = $clog2(BLOCK_BYTES);

  // limit registers
  logic [7:0]  idle_clk_r, poll_lim_r;
  logic [15:0] retry_lim_r, busy_to_r;

  // sequencer state
  sdsh_pkg::phase_t phase_r, phase_nxt;
  sdsh_pkg::cont_t  cont_r, cont_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        ready_r, ready_nxt;
  logic [BIW-1:0] bidx_r, bidx_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [5:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic [7:0]  ocr_r [4];
  logic        legacy_r, legacy_nxt;
  logic [1:0]  fstat_r, fstat_nxt;
  logic        cs_r, cs_nxt;

  sdsh_pkg::out_item_t res, out_r;
  logic out_v_r;

  logic take;
  assign in_ready  = !out_v_r || out_ready;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic [15:0] retry_init1, busy1;
  logic [7:0]  poll1;
  assign retry_init1 = (retry_lim_r == 16'd0) ? 16'd1 : retry_lim_r;
  assign busy1       = (busy_to_r == 16'd0) ? 16'd1 : busy_to_r;
  assign poll1       = (poll_lim_r == 8'd0) ? 8'd1 : poll_lim_r;

  logic [7:0] rx;
  assign rx = in_data.rx_byte;

  // command frame byte for the index after increment
  function automatic logic [7:0] cmd_byte(input logic [BIW-1:0] i, input logic [5:0] c,
                                          input logic [31:0] a);
    logic [7:0] b;
    b = 8'h01;
    unique case (i[2:0])
      3'd0: b = sdsh_pkg::FILL_BYTE;
      3'd1: b = {2'b01, c};
      3'd2: b = a[31:24];
      3'd3: b = a[23:16];
      3'd4: b = a[15:8];
      3'd5: b = a[7:0];
      default: begin
        if (c == sdsh_pkg::CMD_GO_IDLE) b = 8'h95;
        else if (c == sdsh_pkg::CMD_SEND_IF) b = 8'h87;
        else b = 8'h01;
      end
    endcase
    return b;
  endfunction

  logic       ocr_we;
  logic [1:0] ocr_wa;

  always_comb begin
    logic [15:0] rdec;
    logic [31:0] addr;
    phase_nxt = phase_r; cont_nxt = cont_r; kind_nxt = kind_r; ready_nxt = ready_r;
    bidx_nxt = bidx_r; retry_nxt = retry_r; poll_nxt = poll_r; cidx_nxt = cidx_r;
    carg_nxt = carg_r; legacy_nxt = legacy_r; fstat_nxt = fstat_r; cs_nxt = cs_r;
    ocr_we = 1'b0; ocr_wa = bidx_r[1:0];
    rdec = retry_r - 16'd1;
    addr = (kind_r == sdsh_pkg::KIND_SDHC) ? in_data.sector
         : in_data.sector * 32'(BLOCK_BYTES);
    res = '0;
    res.chip_select_low = cs_r;

    // helper macros written inline: send(b,cs)
    if (in_data.operation == sdsh_pkg::OP_START && phase_r == sdsh_pkg::P_IDLE) begin
      if (in_data.request == sdsh_pkg::REQ_INIT) begin
        res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE;
        if (idle_clk_r == 8'd0) begin
          cidx_nxt = sdsh_pkg::CMD_GO_IDLE; carg_nxt = '0; cont_nxt = sdsh_pkg::X_CMD0;
          phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0; res.chip_select_low = 1'b1;
        end else begin
          phase_nxt = sdsh_pkg::P_CLK; bidx_nxt = BIW'(1); res.chip_select_low = 1'b0;
        end
      end else if (in_data.request == sdsh_pkg::REQ_SYNC) begin
        retry_nxt = busy1; phase_nxt = sdsh_pkg::P_SYNC;
        res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE; res.chip_select_low = 1'b1;
      end else if (!ready_r) begin
        res.done_res = 1'b1; res.status = sdsh_pkg::ST_NOTINIT; res.chip_select_low = 1'b0;
      end else if (in_data.block_count != 8'd1) begin
        fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
        res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE; res.chip_select_low = 1'b0;
      end else begin
        cidx_nxt = (in_data.request == sdsh_pkg::REQ_READ) ? sdsh_pkg::CMD_READ
                                                           : sdsh_pkg::CMD_WRITE;
        cont_nxt = (in_data.request == sdsh_pkg::REQ_READ) ? sdsh_pkg::X_CMD17
                                                           : sdsh_pkg::X_CMD24;
        carg_nxt = addr; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
        res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE; res.chip_select_low = 1'b1;
      end
    end else if (in_data.operation == sdsh_pkg::OP_RETURN && phase_r != sdsh_pkg::P_IDLE
                 && phase_r != sdsh_pkg::P_WNEED) begin
      // default exchange: 0xff with cs low asserted (cs_low=1)
      res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE; res.chip_select_low = 1'b1;
      unique case (phase_r)
        sdsh_pkg::P_CLK: begin
          if (BIW'(idle_clk_r) > bidx_r || (BIW < 8 && 1'b0)) begin
            bidx_nxt = bidx_r + 1'b1; res.chip_select_low = 1'b0;
          end else begin
            cidx_nxt = sdsh_pkg::CMD_GO_IDLE; carg_nxt = '0; cont_nxt = sdsh_pkg::X_CMD0;
            phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
          end
        end
        sdsh_pkg::P_CMD: begin
          if (bidx_r < BIW'(6)) begin
            bidx_nxt = bidx_r + 1'b1;
            res.tx_byte = cmd_byte(bidx_r + 1'b1, cidx_r, carg_r);
          end else begin
            poll_nxt = poll1; phase_nxt = sdsh_pkg::P_POLL;
          end
        end
        sdsh_pkg::P_POLL: begin
          if (rx[7] && poll_r != 8'd1) begin
            poll_nxt = poll_r - 8'd1;
          end else begin
            poll_nxt = poll_r - 8'd1;
            // command finished, rx is the response
            unique case (cont_r)
              sdsh_pkg::X_CMD0: begin
                if (rx == 8'd1) begin
                  cidx_nxt = sdsh_pkg::CMD_SEND_IF; carg_nxt = 32'h1AA;
                  cont_nxt = sdsh_pkg::X_CMD8; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
                end else begin
                  kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
                  fstat_nxt = sdsh_pkg::ST_NOTINIT; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_CMD8: begin
                if (rx == 8'd1) begin
                  cont_nxt = sdsh_pkg::X_OCR8; phase_nxt = sdsh_pkg::P_OCR; bidx_nxt = '0;
                end else begin
                  cont_nxt = sdsh_pkg::X_V1_55; phase_nxt = sdsh_pkg::P_PULSE;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_V2_55: begin
                retry_nxt = rdec; cidx_nxt = sdsh_pkg::CMD_APP_OP; carg_nxt = 32'h40000000;
                cont_nxt = sdsh_pkg::X_V2_41; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
              end
              sdsh_pkg::X_V2_41: begin
                if (rx != 8'd0 && retry_r != 16'd0) begin
                  cont_nxt = sdsh_pkg::X_V2_55; phase_nxt = sdsh_pkg::P_PULSE;
                  res.chip_select_low = 1'b0;
                end else if (retry_r != 16'd0) begin
                  cidx_nxt = sdsh_pkg::CMD_READ_OCR; carg_nxt = '0;
                  cont_nxt = sdsh_pkg::X_CMD58; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
                end else begin
                  kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
                  fstat_nxt = sdsh_pkg::ST_NOTINIT; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_CMD58: begin
                if (rx == 8'd0) begin
                  cont_nxt = sdsh_pkg::X_OCR58; phase_nxt = sdsh_pkg::P_OCR; bidx_nxt = '0;
                end else begin
                  kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
                  fstat_nxt = sdsh_pkg::ST_NOTINIT; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_V1_55: begin
                cidx_nxt = sdsh_pkg::CMD_APP_OP; carg_nxt = '0;
                cont_nxt = sdsh_pkg::X_V1_PROBE; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
              end
              sdsh_pkg::X_V1_PROBE: begin
                legacy_nxt = (rx > 8'd1);
                if (rx > 8'd1) begin
                  retry_nxt = retry_init1 - 16'd1; cidx_nxt = sdsh_pkg::CMD_OP_MMC;
                  carg_nxt = '0; cont_nxt = sdsh_pkg::X_V1_LOOP;
                  phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
                end else begin
                  retry_nxt = retry_init1;
                  cont_nxt = sdsh_pkg::X_V1L_55; phase_nxt = sdsh_pkg::P_PULSE;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_V1L_55: begin
                retry_nxt = rdec; cidx_nxt = sdsh_pkg::CMD_APP_OP; carg_nxt = '0;
                cont_nxt = sdsh_pkg::X_V1_LOOP; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
              end
              sdsh_pkg::X_V1_LOOP: begin
                if (rx != 8'd0 && retry_r != 16'd0) begin
                  if (!legacy_r) begin
                    cont_nxt = sdsh_pkg::X_V1L_55; phase_nxt = sdsh_pkg::P_PULSE;
                    res.chip_select_low = 1'b0;
                  end else begin
                    retry_nxt = rdec; cidx_nxt = sdsh_pkg::CMD_OP_MMC; carg_nxt = '0;
                    cont_nxt = sdsh_pkg::X_V1_LOOP; phase_nxt = sdsh_pkg::P_CMD;
                    bidx_nxt = '0;
                  end
                end else if (retry_r == 16'd0) begin
                  kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
                  fstat_nxt = sdsh_pkg::ST_NOTINIT; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end else begin
                  cidx_nxt = sdsh_pkg::CMD_BLKLEN; carg_nxt = 32'(BLOCK_BYTES);
                  cont_nxt = sdsh_pkg::X_CMD16; phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
                end
              end
              sdsh_pkg::X_CMD16: begin
                if (rx == 8'd0) begin
                  kind_nxt = legacy_r ? sdsh_pkg::KIND_MMC : sdsh_pkg::KIND_SDB;
                  ready_nxt = 1'b1; fstat_nxt = sdsh_pkg::ST_OK;
                end else begin
                  kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
                  fstat_nxt = sdsh_pkg::ST_NOTINIT;
                end
                phase_nxt = sdsh_pkg::P_FINAL; res.chip_select_low = 1'b0;
              end
              sdsh_pkg::X_CMD17: begin
                if (rx == 8'd0) begin
                  retry_nxt = busy1; phase_nxt = sdsh_pkg::P_RTOK;
                end else begin
                  fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end
              end
              sdsh_pkg::X_CMD24: begin
                if (rx == 8'd0) begin
                  phase_nxt = sdsh_pkg::P_WTOK; res.tx_byte = sdsh_pkg::TOKEN_START;
                end else begin
                  fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
                  res.chip_select_low = 1'b0;
                end
              end
              default: begin
                fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
                res.chip_select_low = 1'b0;
              end
            endcase
          end
        end
        sdsh_pkg::P_OCR: begin
          ocr_we = 1'b1;
          if (bidx_r < BIW'(3)) begin
            bidx_nxt = bidx_r + 1'b1;
          end else if (cont_r == sdsh_pkg::X_OCR8) begin
            // byte 3 is rx itself
            if (ocr_r[2] == 8'h01 && rx == 8'hAA) begin
              retry_nxt = retry_init1; cont_nxt = sdsh_pkg::X_V2_55;
              phase_nxt = sdsh_pkg::P_PULSE;
            end else begin
              kind_nxt = sdsh_pkg::KIND_NONE; ready_nxt = 1'b0;
              fstat_nxt = sdsh_pkg::ST_NOTINIT; phase_nxt = sdsh_pkg::P_FINAL;
            end
            res.chip_select_low = 1'b0;
          end else begin
            kind_nxt = ocr_r[0][6] ? sdsh_pkg::KIND_SDHC : sdsh_pkg::KIND_SDB;
            ready_nxt = 1'b1; fstat_nxt = sdsh_pkg::ST_OK; phase_nxt = sdsh_pkg::P_FINAL;
            res.chip_select_low = 1'b0;
          end
        end
        sdsh_pkg::P_PULSE: begin
          cidx_nxt = sdsh_pkg::CMD_APP; carg_nxt = '0;
          phase_nxt = sdsh_pkg::P_CMD; bidx_nxt = '0;
        end
        sdsh_pkg::P_RTOK: begin
          if (rx == sdsh_pkg::TOKEN_START) begin
            bidx_nxt = '0; phase_nxt = sdsh_pkg::P_RDAT;
          end else begin
            retry_nxt = rdec;
            if (rdec == 16'd0) begin
              fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
              res.chip_select_low = 1'b0;
            end
          end
        end
        sdsh_pkg::P_RDAT: begin
          res.read_data = rx; res.read_valid = 1'b1;
          if (bidx_r != BIW'(BLOCK_BYTES - 1)) bidx_nxt = bidx_r + 1'b1;
          else begin
            phase_nxt = sdsh_pkg::P_RCRC; bidx_nxt = '0;
          end
        end
        sdsh_pkg::P_RCRC: begin
          if (bidx_r == '0) bidx_nxt = BIW'(1);
          else begin
            fstat_nxt = sdsh_pkg::ST_OK; phase_nxt = sdsh_pkg::P_FINAL;
            res.chip_select_low = 1'b0;
          end
        end
        sdsh_pkg::P_WTOK: begin
          bidx_nxt = '0; phase_nxt = sdsh_pkg::P_WNEED;
          res.tx_valid = 1'b0; res.tx_byte = '0;
        end
        sdsh_pkg::P_WDAT: begin
          res.tx_valid = 1'b0; res.tx_byte = '0; res.chip_select_low = cs_r;
          if (bidx_r != BIW'(BLOCK_BYTES - 1)) begin
            bidx_nxt = bidx_r + 1'b1; phase_nxt = sdsh_pkg::P_WNEED;
          end else begin
            bidx_nxt = '0; phase_nxt = sdsh_pkg::P_WCRC;
            res.tx_valid = 1'b1; res.tx_byte = sdsh_pkg::FILL_BYTE;
            res.chip_select_low = 1'b1;
          end
        end
        sdsh_pkg::P_WCRC: begin
          if (bidx_r == '0) bidx_nxt = BIW'(1);
          else phase_nxt = sdsh_pkg::P_WRESP;
        end
        sdsh_pkg::P_WRESP: begin
          if (rx[4:0] == 5'h05) begin
            retry_nxt = busy1; phase_nxt = sdsh_pkg::P_WBUSY;
          end else begin
            fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
            res.chip_select_low = 1'b0;
          end
        end
        sdsh_pkg::P_WBUSY: begin
          if (rx == 8'd0) begin
            retry_nxt = rdec;
            if (rdec == 16'd0) begin
              fstat_nxt = sdsh_pkg::ST_ERROR; phase_nxt = sdsh_pkg::P_FINAL;
              res.chip_select_low = 1'b0;
            end
          end else begin
            fstat_nxt = sdsh_pkg::ST_OK; phase_nxt = sdsh_pkg::P_FINAL;
            res.chip_select_low = 1'b0;
          end
        end
        sdsh_pkg::P_SYNC: begin
          if (rx == 8'd0) retry_nxt = rdec;
          if (rx != 8'd0 || rdec == 16'd0) begin
            phase_nxt = sdsh_pkg::P_IDLE; res.tx_valid = 1'b0; res.tx_byte = '0;
            res.done_res = 1'b1; res.status = sdsh_pkg::ST_OK;
            res.chip_select_low = 1'b0;
          end
        end
        sdsh_pkg::P_FINAL: begin
          phase_nxt = sdsh_pkg::P_IDLE; res.tx_valid = 1'b0; res.tx_byte = '0;
          res.done_res = 1'b1; res.status = fstat_r; res.chip_select_low = 1'b0;
        end
        default: begin
          res.tx_valid = 1'b0; res.tx_byte = '0; res.chip_select_low = cs_r;
        end
      endcase
    end else if (in_data.operation == sdsh_pkg::OP_WDATA && phase_r == sdsh_pkg::P_WNEED) begin
      phase_nxt = sdsh_pkg::P_WDAT;
      res.tx_valid = 1'b1; res.tx_byte = in_data.write_data; res.chip_select_low = 1'b1;
    end
    if (res.tx_valid || res.done_res) cs_nxt = res.chip_select_low;
    if (phase_nxt == sdsh_pkg::P_WNEED && !res.tx_valid) res.want_write_data = 1'b1;
    res.card_kind = kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (take && ocr_we) ocr_r[ocr_wa] <= rx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_clk_r <= 8'd10; poll_lim_r <= 8'd10;
      retry_lim_r <= 16'd1000; busy_to_r <= 16'd5000;
      phase_r <= sdsh_pkg::P_IDLE; cont_r <= sdsh_pkg::X_CMD0;
      kind_r <= sdsh_pkg::KIND_NONE; ready_r <= 1'b0; bidx_r <= '0;
      retry_r <= '0; poll_r <= '0; cidx_r <= '0; carg_r <= '0;
      legacy_r <= 1'b0; fstat_r <= sdsh_pkg::ST_OK; cs_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sdsh_pkg::CFG_IDLE_CLK: idle_clk_r <= cfg_data[7:0];
          sdsh_pkg::CFG_POLL:     poll_lim_r <= cfg_data[7:0];
          sdsh_pkg::CFG_RETRY:    retry_lim_r <= cfg_data;
          sdsh_pkg::CFG_BUSY:     busy_to_r <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        phase_r <= phase_nxt; cont_r <= cont_nxt; kind_r <= kind_nxt;
        ready_r <= ready_nxt; bidx_r <= bidx_nxt; retry_r <= retry_nxt;
        poll_r <= poll_nxt; cidx_r <= cidx_nxt; carg_r <= carg_nxt;
        legacy_r <= legacy_nxt; fstat_r <= fstat_nxt; cs_r <= cs_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_r <= res;
  end

endmodule

### rtl/sdsh_checker.sv
// checker: port-level properties of the sd card spi host sequencer
module sdsh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sdsh_pkg::out_item_t out_data
);

  // an accepted transfer always produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("missing result");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result changed");

  // done never comes together with an exchange request
  a_done_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.tx_valid && !out_data.chip_select_low)
    else $error("done with exchange");

  // read data only alongside an exchange
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.tx_valid) else $error("read without tx");

endmodule

bind sd_card_spi_host_sequencer_core sdsh_checker u_sdsh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### test/sd_card_spi_host_sequencer_core_test.sv
// testbench: sd card spi host sequencer checked against a behavioral predictor and card model
`timescale 1ns / 100ps

module sd_card_spi_host_sequencer_core_test;
  import sdsh_pkg::*;

  localparam int NBYTES = 512;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_IDLE_CLK;
  logic [15:0] cfg_data = '0;

  sd_card_spi_host_sequencer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted copy of the sequencer state
  int unsigned lim_idle, lim_poll, lim_retry, lim_busy;
  phase_t      sq_phase;
  logic [1:0]  sq_kind;
  logic        sq_ready;
  int unsigned sq_idx;
  logic [15:0] sq_retry;
  logic [7:0]  sq_poll;
  logic [5:0]  sq_cmd;
  logic [31:0] sq_arg;
  logic [7:0]  sq_ocr [4];
  logic        sq_legacy;
  cont_t       sq_cont;
  logic [1:0]  sq_final;
  logic        sq_cs;
  out_item_t   step_res;

  out_item_t   expected_q[$];
  out_item_t   last_res;
  int          mismatches = 0;
  int          checked = 0;
  int          requests_run = 0;
  int          card_prof = 0;   // 0 sdhc, 1 sd byte, 2 sd v1, 3 mmc, 4 silent
  int          burst_left = 0;
  int          hold_start = 0;

  function automatic logic [15:0] nonzero16(int unsigned v);
    return (v[15:0] == 0) ? 16'd1 : v[15:0];
  endfunction

  task automatic pred_reset();
    lim_idle = 10; lim_poll = 10; lim_retry = 1000; lim_busy = 5000;
    sq_phase = P_IDLE; sq_kind = KIND_NONE; sq_ready = 0; sq_idx = 0;
    sq_retry = 0; sq_poll = 0; sq_cmd = 0; sq_arg = 0; sq_legacy = 0;
    for (int i = 0; i < 4; i++) sq_ocr[i] = 0;
    sq_cont = X_CMD0; sq_final = ST_OK; sq_cs = 0;
  endtask

  task automatic emit(logic [7:0] b, logic cs);
    step_res.tx_byte = b; step_res.tx_valid = 1; step_res.chip_select_low = cs; sq_cs = cs;
  endtask

  function automatic logic [7:0] frame_byte(int unsigned i);
    if (i == 0) return FILL_BYTE;
    if (i == 1) return 8'h40 | {2'b00, sq_cmd};
    if (i <= 5) return sq_arg >> (8 * (5 - i));
    if (sq_cmd == CMD_GO_IDLE) return 8'h95;
    if (sq_cmd == CMD_SEND_IF) return 8'h87;
    return 8'h01;
  endfunction

  task automatic issue_cmd(logic [5:0] c, logic [31:0] a, cont_t k);
    sq_cmd = c; sq_arg = a; sq_cont = k; sq_phase = P_CMD; sq_idx = 0; emit(FILL_BYTE, 1);
  endtask

  task automatic pulse_cs(cont_t k);
    sq_cont = k; sq_phase = P_PULSE; emit(FILL_BYTE, 0);
  endtask

  task automatic fetch_ocr(cont_t k);
    sq_cont = k; sq_phase = P_OCR; sq_idx = 0; emit(FILL_BYTE, 1);
  endtask

  task automatic close_out(logic [1:0] st);
    sq_final = st; sq_phase = P_FINAL; emit(FILL_BYTE, 0);
  endtask

  task automatic init_over(logic [1:0] k);
    sq_kind = k; sq_ready = (k != KIND_NONE); close_out(k != KIND_NONE ? ST_OK : ST_NOTINIT);
  endtask

  task automatic end_now(logic [1:0] st);
    sq_phase = P_IDLE; step_res.done_res = 1; step_res.status = st;
    step_res.chip_select_low = 0; sq_cs = 0;
  endtask

  task automatic v1_round();
    if (!sq_legacy) pulse_cs(X_V1L_55);
    else begin
      sq_retry = sq_retry - 1;
      issue_cmd(CMD_OP_MMC, 0, X_V1_LOOP);
    end
  endtask

  // reaction to the r1 byte of a finished command
  task automatic on_response(logic [7:0] r);
    case (sq_cont)
      X_CMD0: if (r == 1) issue_cmd(CMD_SEND_IF, 32'h1AA, X_CMD8); else init_over(KIND_NONE);
      X_CMD8: if (r == 1) fetch_ocr(X_OCR8); else pulse_cs(X_V1_55);
      X_V2_55: begin
        sq_retry = sq_retry - 1;
        issue_cmd(CMD_APP_OP, 32'h40000000, X_V2_41);
      end
      X_V2_41: begin
        if (r != 0 && sq_retry != 0) pulse_cs(X_V2_55);
        else if (sq_retry != 0) issue_cmd(CMD_READ_OCR, 0, X_CMD58);
        else init_over(KIND_NONE);
      end
      X_CMD58: if (r == 0) fetch_ocr(X_OCR58); else init_over(KIND_NONE);
      X_V1_55: issue_cmd(CMD_APP_OP, 0, X_V1_PROBE);
      X_V1_PROBE: begin
        sq_legacy = (r > 1);
        sq_retry = nonzero16(lim_retry);
        v1_round();
      end
      X_V1L_55: begin
        sq_retry = sq_retry - 1;
        issue_cmd(CMD_APP_OP, 0, X_V1_LOOP);
      end
      X_V1_LOOP: begin
        if (r != 0 && sq_retry != 0) v1_round();
        else if (sq_retry == 0) init_over(KIND_NONE);
        else issue_cmd(CMD_BLKLEN, NBYTES, X_CMD16);
      end
      X_CMD16: init_over(r == 0 ? (sq_legacy ? KIND_MMC : KIND_SDB) : KIND_NONE);
      X_CMD17: begin
        if (r == 0) begin
          sq_retry = nonzero16(lim_busy); sq_phase = P_RTOK; emit(FILL_BYTE, 1);
        end else close_out(ST_ERROR);
      end
      X_CMD24: begin
        if (r == 0) begin
          sq_phase = P_WTOK; emit(TOKEN_START, 1);
        end else close_out(ST_ERROR);
      end
      default: close_out(ST_ERROR);
    endcase
  endtask

  task automatic on_card_byte(logic [7:0] rx);
    case (sq_phase)
      P_CLK: begin
        if (sq_idx < lim_idle) begin
          sq_idx++; emit(FILL_BYTE, 0);
        end else issue_cmd(CMD_GO_IDLE, 0, X_CMD0);
      end
      P_CMD: begin
        if (sq_idx < 6) begin
          sq_idx++; emit(frame_byte(sq_idx), 1);
        end else begin
          sq_poll = (lim_poll == 0) ? 8'd1 : lim_poll[7:0];
          sq_phase = P_POLL; emit(FILL_BYTE, 1);
        end
      end
      P_POLL: begin
        if (rx[7]) begin
          sq_poll = sq_poll - 1;
          if (sq_poll != 0) emit(FILL_BYTE, 1); else on_response(rx);
        end else on_response(rx);
      end
      P_OCR: begin
        sq_ocr[sq_idx & 3] = rx;
        if (sq_idx < 3) begin
          sq_idx++; emit(FILL_BYTE, 1);
        end else if (sq_cont == X_OCR8) begin
          if (sq_ocr[2] == 8'h01 && sq_ocr[3] == 8'hAA) begin
            sq_retry = nonzero16(lim_retry); pulse_cs(X_V2_55);
          end else init_over(KIND_NONE);
        end else init_over(sq_ocr[0][6] ? KIND_SDHC : KIND_SDB);
      end
      P_PULSE: issue_cmd(CMD_APP, 0, sq_cont);
      P_RTOK: begin
        if (rx == TOKEN_START) begin
          sq_idx = 0; sq_phase = P_RDAT; emit(FILL_BYTE, 1);
        end else begin
          sq_retry = sq_retry - 1;
          if (sq_retry != 0) emit(FILL_BYTE, 1); else close_out(ST_ERROR);
        end
      end
      P_RDAT: begin
        step_res.read_data = rx; step_res.read_valid = 1;
        if (sq_idx < NBYTES - 1) sq_idx++;
        else begin
          sq_phase = P_RCRC; sq_idx = 0;
        end
        emit(FILL_BYTE, 1);
      end
      P_RCRC: begin
        if (sq_idx == 0) begin
          sq_idx = 1; emit(FILL_BYTE, 1);
        end else close_out(ST_OK);
      end
      P_WTOK: begin
        sq_idx = 0; sq_phase = P_WNEED; step_res.chip_select_low = 1;
      end
      P_WDAT: begin
        sq_idx++;
        if (sq_idx < NBYTES) sq_phase = P_WNEED;
        else begin
          sq_phase = P_WCRC; sq_idx = 0; emit(FILL_BYTE, 1);
        end
      end
      P_WCRC: begin
        if (sq_idx == 0) sq_idx = 1; else sq_phase = P_WRESP;
        emit(FILL_BYTE, 1);
      end
      P_WRESP: begin
        if (rx[4:0] == 5'h05) begin
          sq_retry = nonzero16(lim_busy); sq_phase = P_WBUSY; emit(FILL_BYTE, 1);
        end else close_out(ST_ERROR);
      end
      P_WBUSY: begin
        if (rx == 0) begin
          sq_retry = sq_retry - 1;
          if (sq_retry != 0) emit(FILL_BYTE, 1); else close_out(ST_ERROR);
        end else close_out(ST_OK);
      end
      P_SYNC: begin
        if (rx == 0) begin
          sq_retry = sq_retry - 1;
          if (sq_retry != 0) emit(FILL_BYTE, 1); else end_now(ST_OK);
        end else end_now(ST_OK);
      end
      P_FINAL: end_now(sq_final);
      default: ;
    endcase
  endtask

  task automatic start_req(in_item_t it);
    logic [31:0] addr;
    if (it.request == REQ_INIT) begin
      if (lim_idle == 0) issue_cmd(CMD_GO_IDLE, 0, X_CMD0);
      else begin
        sq_phase = P_CLK; sq_idx = 1; emit(FILL_BYTE, 0);
      end
    end else if (it.request == REQ_SYNC) begin
      sq_retry = nonzero16(lim_busy); sq_phase = P_SYNC; emit(FILL_BYTE, 1);
    end else if (!sq_ready) end_now(ST_NOTINIT);
    else begin
      addr = (sq_kind == KIND_SDHC) ? it.sector : it.sector * NBYTES;
      if (it.block_count != 1) close_out(ST_ERROR);
      else if (it.request == REQ_READ) issue_cmd(CMD_READ, addr, X_CMD17);
      else issue_cmd(CMD_WRITE, addr, X_CMD24);
    end
  endtask

  // one accepted input transfer -> the one result it produces
  task automatic predict_step(in_item_t it);
    step_res = '0;
    step_res.chip_select_low = sq_cs;
    if (it.operation == OP_START && sq_phase == P_IDLE) start_req(it);
    else if (it.operation == OP_RETURN && sq_phase != P_IDLE && sq_phase != P_WNEED)
      on_card_byte(it.rx_byte);
    else if (it.operation == OP_WDATA && sq_phase == P_WNEED) begin
      sq_phase = P_WDAT; emit(it.write_data, 1);
    end
    if (sq_phase == P_WNEED && !step_res.tx_valid) step_res.want_write_data = 1;
    step_res.card_kind = sq_kind;
  endtask

  // sender: bursts with random gaps; valid stays up between back-to-back transfers
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_step(it);
    expected_q.push_back(step_res);
    last_res = step_res;
  endtask

  task automatic wait_drained();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limits(int unsigned vi, int unsigned vp, int unsigned vr, int unsigned vb);
    int unsigned vals[4];
    wait_drained();
    vals = '{vi, vp, vr, vb};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i][15:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (i[1:0])
        CFG_IDLE_CLK: lim_idle = vals[i] & 8'hFF;
        CFG_POLL:     lim_poll = vals[i] & 8'hFF;
        CFG_RETRY:    lim_retry = vals[i] & 16'hFFFF;
        default:      lim_busy = vals[i] & 16'hFFFF;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // r1 answer the emulated card gives to the command in flight
  function automatic logic [7:0] card_r1();
    if (card_prof == 4) return 8'hFF;
    case (sq_cont)
      X_CMD0:     return ($urandom_range(0, 19) == 0) ? 8'h00 : 8'h01;
      X_CMD8:     return (card_prof < 2) ? 8'h01 : 8'h05;
      X_V2_41:    return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
      X_CMD58:    return 8'h00;
      X_V1_PROBE: return (card_prof == 3) ? 8'h05 : 8'h01;
      X_V1_LOOP:  return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
      X_CMD16:    return ($urandom_range(0, 9) == 0) ? 8'h04 : 8'h00;
      X_CMD17, X_CMD24: return ($urandom_range(0, 7) == 0) ? 8'h04 : 8'h00;
      default:    return 8'h01;
    endcase
  endfunction

  function automatic logic [7:0] card_byte();
    logic [7:0] echo [4];
    echo = '{8'h00, 8'h00, 8'h01, 8'hAA};
    case (sq_phase)
      P_POLL: begin
        if ($urandom_range(0, 29) == 0) return $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) return {1'b1, 7'($urandom_range(0, 127))};
        return card_r1();
      end
      P_OCR: begin
        if (sq_cont == X_OCR8)
          return ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : echo[sq_idx & 3];
        if (sq_idx == 0) return (card_prof == 0) ? 8'hC0 : 8'h80;
        return $urandom_range(0, 255);
      end
      P_RTOK:  return ($urandom_range(0, 2) == 0) ? TOKEN_START : 8'hFF;
      P_WRESP: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : {3'($urandom_range(0, 7)), 5'h05};
      P_WBUSY, P_SYNC: return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : 8'h00;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.operation = OP_NONE;
    it.request = $urandom_range(0, 3);
    it.sector = $urandom;
    it.block_count = $urandom_range(0, 255);
    it.rx_byte = $urandom_range(0, 255);
    it.write_data = $urandom_range(0, 255);
    return it;
  endfunction

  // noise the block has to ignore: unused opcode, start while busy, wrong byte kind
  function automatic in_item_t stray_item();
    in_item_t it;
    it = rand_fields();
    case ($urandom_range(0, 2))
      0: it.operation = OP_NONE;
      1: it.operation = OP_START;
      default: it.operation = (sq_phase == P_WNEED) ? OP_RETURN : OP_WDATA;
    endcase
    return it;
  endfunction

  // a start and then the card conversation until the request is done
  task automatic run_request(logic [1:0] req, logic [31:0] sec, logic [7:0] cnt, int prof);
    in_item_t it;
    card_prof = prof;
    it = rand_fields();
    it.operation = OP_START; it.request = req; it.sector = sec; it.block_count = cnt;
    send_item(it);
    requests_run++;
    while (sq_phase != P_IDLE) begin
      it = rand_fields();
      if ($urandom_range(0, 39) == 0) it = stray_item();
      else if (sq_phase == P_WNEED) it.operation = OP_WDATA;
      else begin
        it.operation = OP_RETURN;
        it.rx_byte = card_byte();
      end
      send_item(it);
    end
  endtask

  // receiver: stall pattern is redrawn from a free-running cycle counter, plus an optional long hold
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_start != 0) begin
      hold_cnt <= 400;
      hold_start = 0;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!rst_n) out_ready <= 1'b0;
    else case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= $urandom_range(0, 1);
    endcase
  end

  function automatic string show(out_item_t r);
    return $sformatf("tx=%02h/%0d cs=%0d want=%0d rd=%02h/%0d done=%0d st=%0d kind=%0d",
                     r.tx_byte, r.tx_valid, r.chip_select_low, r.want_write_data,
                     r.read_data, r.read_valid, r.done_res, r.status, r.card_kind);
  endfunction

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(out_data));
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d\n  expected %s\n  actual   %s",
                     checked, show(exp_r), show(out_data));
        end
      end
    end
  end

  // --- tests ---

  task automatic test_stray_and_uninit();
    in_item_t it;
    it = rand_fields(); it.operation = OP_NONE; send_item(it);
    it = rand_fields(); it.operation = OP_RETURN; send_item(it);
    it = rand_fields(); it.operation = OP_WDATA; send_item(it);
    run_request(REQ_READ, 32'h0, 8'd1, 0);
    run_request(REQ_WRITE, 32'hFFFFFFFF, 8'd1, 0);
    run_request(REQ_SYNC, 32'h0, 8'd0, 0);
  endtask

  task automatic test_card_kinds();
    for (int p = 0; p < 5; p++) begin
      run_request(REQ_INIT, 32'h0, 8'd1, p);
      if (sq_ready) begin
        run_request(p[0] ? REQ_WRITE : REQ_READ, p[1] ? 32'hFFFFFFFF : 32'h0, 8'd1, p);
        run_request(REQ_READ, $urandom, 8'd0, p);
        run_request(REQ_WRITE, $urandom, 8'd255, p);
      end
    end
  endtask

  task automatic test_limit_extremes();
    write_limits(1, 1, 1, 1);
    run_request(REQ_INIT, 0, 1, 0);
    run_request(REQ_INIT, 0, 1, 3);
    run_request(REQ_SYNC, 0, 1, 0);
    write_limits(0, 0, 0, 0);
    run_request(REQ_INIT, 0, 1, 4);
    run_request(REQ_INIT, 0, 1, 2);
    run_request(REQ_SYNC, 0, 1, 0);
    write_limits(255, 255, 65535, 65535);
    run_request(REQ_INIT, 0, 1, 4);
    run_request(REQ_INIT, 0, 1, 0);
    run_request(REQ_SYNC, 0, 1, 0);
    write_limits(10, 10, 1000, 5000);
  endtask

  task automatic test_output_backpressure();
    card_prof = 0;
    run_request(REQ_INIT, 0, 1, 1);
    hold_start = 1;
    run_request(REQ_READ, $urandom, 8'd1, 1);
  endtask

  task automatic test_random_traffic();
    logic [1:0] req;
    for (int n = 0; n < 50; n++) begin
      if ($urandom_range(0, 9) == 0)
        write_limits($urandom_range(0, 30), $urandom_range(1, 12),
                     $urandom_range(1, 40), $urandom_range(1, 40));
      // block transfers are long, so keep them a small share
      req = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                        : (($urandom_range(0, 1) == 0) ? REQ_INIT : REQ_SYNC);
      run_request(req, $urandom, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : 8'd1,
                  $urandom_range(0, 4));
    end
  endtask

  initial begin
    pred_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_and_uninit();
    test_card_kinds();
    test_limit_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) mismatches += expected_q.size();
    $display("covered %0d requests over all card kinds, limit extremes and a long output hold;",
             requests_run);
    $display("%0d results compared, %0d failures", checked, mismatches);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
